>>> src/scancode_set1_key_decoder_assert.svh
// assertion macros for the scan code set 1 key decoder
`ifndef SCANCODE_SET1_KEY_DECODER_ASSERT_SVH
`define SCANCODE_SET1_KEY_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SC1KD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sc1kd assertion failed");

// next-cycle implication, disabled in reset
`define SC1KD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sc1kd assertion failed");

`endif

>>> src/sc1kd_pkg.sv
// package with types, constants and the character table of the key decoder
package sc1kd_pkg;

  localparam int KEY_COUNT   = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] SC_CTRL   = 7'h1d;
  localparam logic [6:0] SC_LSHIFT = 7'h2a;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3a;
  localparam logic [6:0] SC_NUM    = 7'h45;
  localparam logic [6:0] SC_SCROLL = 7'h46;

  localparam logic [6:0] CHAR_NONE    = 7'h00;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7a;
  localparam logic [6:0] CASE_OFFSET  = 7'h20;

  typedef struct packed {
    logic       brk;
    logic [6:0] code;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  function automatic logic [6:0] char_of(input logic [6:0] key);
    logic [6:0] ch;
    case (key)
      7'd0:  ch = 7'h20;
      7'd2:  ch = 7'h31;
      7'd3:  ch = 7'h32;
      7'd4:  ch = 7'h33;
      7'd5:  ch = 7'h34;
      7'd6:  ch = 7'h35;
      7'd7:  ch = 7'h36;
      7'd8:  ch = 7'h37;
      7'd9:  ch = 7'h38;
      7'd10: ch = 7'h39;
      7'd11: ch = 7'h30;
      7'd12: ch = 7'h2d;
      7'd13: ch = 7'h3d;
      7'd16: ch = 7'h71;
      7'd17: ch = 7'h77;
      7'd18: ch = 7'h65;
      7'd19: ch = 7'h72;
      7'd20: ch = 7'h74;
      7'd21: ch = 7'h79;
      7'd22: ch = 7'h75;
      7'd23: ch = 7'h69;
      7'd24: ch = 7'h6f;
      7'd25: ch = 7'h70;
      7'd26: ch = 7'h5b;
      7'd27: ch = 7'h5d;
      7'd30: ch = 7'h61;
      7'd31: ch = 7'h73;
      7'd32: ch = 7'h64;
      7'd33: ch = 7'h66;
      7'd34: ch = 7'h67;
      7'd35: ch = 7'h68;
      7'd36: ch = 7'h6a;
      7'd37: ch = 7'h6b;
      7'd38: ch = 7'h6c;
      7'd39: ch = 7'h3b;
      7'd40: ch = 7'h27;
      7'd41: ch = 7'h60;
      7'd43: ch = 7'h5c;
      7'd44: ch = 7'h7a;
      7'd45: ch = 7'h78;
      7'd46: ch = 7'h63;
      7'd47: ch = 7'h76;
      7'd48: ch = 7'h62;
      7'd49: ch = 7'h6e;
      7'd50: ch = 7'h6d;
      7'd51: ch = 7'h2c;
      7'd52: ch = 7'h2e;
      7'd53: ch = 7'h2f;
      7'd55: ch = 7'h2a;
      7'd57: ch = 7'h20;
      7'd73: ch = 7'h37;
      7'd74: ch = 7'h38;
      7'd75: ch = 7'h39;
      7'd76: ch = 7'h34;
      7'd77: ch = 7'h35;
      7'd78: ch = 7'h36;
      7'd79: ch = 7'h31;
      7'd80: ch = 7'h32;
      7'd81: ch = 7'h33;
      7'd82: ch = 7'h30;
      7'd83: ch = 7'h2e;
      7'd84: ch = 7'h20;
      7'd85: ch = 7'h20;
      7'd86: ch = 7'h20;
      7'd89: ch = 7'h20;
      7'd90: ch = 7'h20;
      7'd91: ch = 7'h20;
      7'd92: ch = 7'h20;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

>>> src/sc1kd_in_if.sv
// input channel carrying raw scan code bytes
interface sc1kd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_code;

  modport source(output valid, output raw_code, input ready);
  modport sink(input valid, input raw_code, output ready);
endinterface

>>> src/sc1kd_out_if.sv
// output channel carrying decoded key results
interface sc1kd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_code;
  logic       key_down;
  logic [6:0] ascii_char;
  logic       ctrl_down;
  logic       shift_down;
  logic       alt_down;
  logic       caps_key_down;
  logic       num_key_down;
  logic       scroll_key_down;

  modport source(
    output valid, output key_code, output key_down, output ascii_char,
    output ctrl_down, output shift_down, output alt_down,
    output caps_key_down, output num_key_down, output scroll_key_down,
    input ready
  );
  modport sink(
    input valid, input key_code, input key_down, input ascii_char,
    input ctrl_down, input shift_down, input alt_down,
    input caps_key_down, input num_key_down, input scroll_key_down,
    output ready
  );
endinterface

>>> src/sc1kd_front.sv
// front end: accepts scan code bytes, splits make/break and queues them
module sc1kd_front #(
  parameter int QUEUE_DEPTH = sc1kd_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  sc1kd_in_if.sink               codes,
  output sc1kd_pkg::queue_head_t head,
  input  logic                   pop
);
  import sc1kd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  cmd_t             cmd_in;

  assign cmd_in.brk  = codes.raw_code[7];
  assign cmd_in.code = codes.raw_code[6:0];

  assign codes.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push        = codes.valid && codes.ready;
  assign do_pop      = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/sc1kd_back.sv
// back end: updates the key down map and registers one result per item
module sc1kd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sc1kd_pkg::queue_head_t head,
  output logic                   pop,
  sc1kd_out_if.source            keys
);
  import sc1kd_pkg::*;

  logic [KEY_COUNT-1:0] key_down_map;
  logic [KEY_COUNT-1:0] key_down_map_next;
  logic [6:0]           key;
  logic [6:0]           ch_raw;
  logic [6:0]           ch;
  logic                 shift;
  logic                 valid;
  logic                 map_shift;

  assign pop = head.valid && (!valid || keys.ready);

  always_comb begin
    key_down_map_next = key_down_map;
    if (pop) begin
      key_down_map_next[head.cmd.code] = !head.cmd.brk;
    end
    key    = head.cmd.brk ? 7'd0 : head.cmd.code;
    shift  = key_down_map_next[SC_LSHIFT] | key_down_map_next[SC_RSHIFT];
    ch_raw = char_of(key);
    if (shift && ch_raw >= CHAR_LOWER_A && ch_raw <= CHAR_LOWER_Z) begin
      ch = ch_raw - CASE_OFFSET;
    end else begin
      ch = ch_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down_map <= '0;
      valid        <= 1'b0;
    end else begin
      key_down_map <= key_down_map_next;
      if (pop) begin
        valid <= 1'b1;
      end else if (keys.ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      keys.key_code        <= key;
      keys.key_down        <= key_down_map_next[key];
      keys.ascii_char      <= ch;
      keys.ctrl_down       <= key_down_map_next[SC_CTRL];
      keys.shift_down      <= shift;
      keys.alt_down        <= key_down_map_next[SC_ALT];
      keys.caps_key_down   <= key_down_map_next[SC_CAPS];
      keys.num_key_down    <= key_down_map_next[SC_NUM];
      keys.scroll_key_down <= key_down_map_next[SC_SCROLL];
    end
  end

  assign keys.valid = valid;

  assign map_shift = key_down_map[SC_LSHIFT] | key_down_map[SC_RSHIFT];

`include "scancode_set1_key_decoder_assert.svh"

  `SC1KD_ASSERT_NEXT(a_make_sets_map, pop && !head.cmd.brk, key_down_map[$past(head.cmd.code)])
  `SC1KD_ASSERT_NEXT(a_break_clears_map, pop && head.cmd.brk, !key_down_map[$past(head.cmd.code)])
  `SC1KD_ASSERT_NEXT(a_break_reports_zero, pop && head.cmd.brk, keys.key_code == 7'd0)
  `SC1KD_ASSERT_NOW(a_shift_matches_map, valid, keys.shift_down == map_shift)

endmodule

>>> src/scancode_set1_key_decoder.sv
// top level of the scan code set 1 key decoder
//
// codes: one raw scan code set 1 byte per item; bit 7 marks a key release,
//   bits 6..0 name the key
// keys: one result per accepted byte: key code (zero on a release), its down
//   bit, the ascii character and the modifier down flags
// path: an accepted byte is written to a queue slot, then decoded into the result
//   register
// throughput: one byte per cycle while keys.ready stays high, set by the key map update in the
//   back end, which forwards its own write to the result lookup
// a small queue between front and back absorbs short stalls on either side
// when the receiver stalls, the result register holds, the queue fills and
//   codes.ready drops once all queue slots are taken
// reset clears the key map (all keys up), the queue and the result valid
module scancode_set1_key_decoder #(
  parameter int QUEUE_DEPTH = sc1kd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  sc1kd_in_if.sink    codes,
  sc1kd_out_if.source keys
);
  import sc1kd_pkg::*;

  queue_head_t head;
  logic        pop;

  sc1kd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .codes(codes),
    .head (head),
    .pop  (pop)
  );

  sc1kd_back u_back (
    .clk (clk),
    .rst (rst),
    .head(head),
    .pop (pop),
    .keys(keys)
  );

endmodule
